// File: hw/rtl/cross_unsharp_sharpen_unit_assert.svh
// Assertion macros for the cross unsharp sharpen unit.
`ifndef CROSS_UNSHARP_SHARPEN_UNIT_ASSERT_SVH
`define CROSS_UNSHARP_SHARPEN_UNIT_ASSERT_SVH
// Same-cycle implication, off during reset.
`define CUSU_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("cusu assertion failed");
// Next-cycle implication, off during reset.
`define CUSU_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("cusu assertion failed");
// Next-cycle implication that also holds during reset.
`define CUSU_ASSERT_ALWAYS_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("cusu assertion failed");
`endif

// File: hw/rtl/cusu_pkg.sv
// Package with the shared types, codes and arithmetic of the sharpen unit.
package cusu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SHARPEN_GAIN = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] cen;
    logic [23:0] north;
    logic [23:0] south;
    logic [23:0] east;
    logic [23:0] west;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        run_last;
    logic        frame_last;
  } job_t;

  function automatic logic signed [30:0] chan_prod(input logic [7:0] cen, input logic [7:0] n,
                                                   input logic [7:0] s, input logic [7:0] e,
                                                   input logic [7:0] w,
                                                   input logic signed [21:0] gain);
    logic [9:0] sum;
    logic signed [8:0] diff;
    sum = {2'b00, n} + {2'b00, s} + {2'b00, e} + {2'b00, w};
    diff = $signed({1'b0, cen}) - $signed({1'b0, sum[9:2]});
    return gain * diff;
  endfunction

  function automatic logic [7:0] chan_sat(input logic [7:0] cen,
                                          input logic signed [30:0] prod);
    logic signed [14:0] q;
    logic signed [15:0] v;
    q = prod[30:16];
    v = $signed({8'b0, cen}) + $signed({q[14], q});
    if (v < 0) begin
      return 8'd0;
    end else if (v > 16'sd255) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

endpackage

// File: hw/rtl/cusu_ifs.sv
// Stream interfaces for the pixel input and the result output.
interface cusu_pix_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface cusu_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_out;
  logic [9:0]  out_column;
  logic [9:0]  out_row;
  logic        run_last;
  logic        frame_last;
  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output run_last, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input out_column, input out_row,
                input run_last, input frame_last, output ready);
endinterface

// File: hw/rtl/cross_unsharp_sharpen_unit.sv
// A pixel's result is made once the input completing its neighborhood is taken, one
// row and one pixel after the pixel (less at the last column and row), then passes
// the window, queue, sharpen and output registers. Throughput: one pixel per cycle
// while the queue has room; an input waits until its results, up to four, are pushed.
// Reset is synchronous and clears counters, window, queue and configuration;
// the line stores keep their contents.
module cross_unsharp_sharpen_unit import cusu_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  cusu_pix_if.sink    in_ch,
  cusu_res_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  logic [10:0] frame_width_r, frame_height_r;
  logic [21:0] sharpen_gain_r;
  job_t job, head;
  logic job_push, job_full, pop, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= 11'd1024;
      frame_height_r <= 11'd1024;
      sharpen_gain_r <= 22'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r <= cfg_data[10:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[10:0];
        CFG_SHARPEN_GAIN: sharpen_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cusu_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .job(job), .job_push(job_push), .job_full(job_full)
  );

  cusu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_job(job), .push(job_push), .full(job_full),
    .head(head), .pop(pop), .empty(empty)
  );

  cusu_back u_back (
    .clk(clk), .rst_n(rst_n), .sharpen_gain(sharpen_gain_r),
    .head(head), .empty(empty), .pop(pop), .out_ch(out_ch)
  );

endmodule

// File: hw/rtl/cusu_front.sv
// Front end: raster counters, line stores, window and result job sequencer.
module cusu_front import cusu_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  cusu_pix_if.sink    in_ch,
  input  logic [10:0] frame_width,
  input  logic [10:0] frame_height,
  output job_t        job,
  output logic        job_push,
  input  logic        job_full
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = CW + 1;

  logic [23:0] mem [2**AW];
  logic [23:0] mid_q, north_q;

  logic [CW-1:0] wd_m1, c, col_r;
  logic [RW-1:0] ht_m1, r, row_r;
  logic bank_r, lastc, lastr, c_nz, r_nz, accept;
  logic [23:0] p;

  logic          pend_v_r;
  logic [AW-1:0] pend_addr_r;
  logic [23:0]   pend_data_r;
  logic [23:0]   last_p_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [23:0]   wr_data;

  logic          b_valid_r;
  logic [3:0]    mask_r, pick, mask_after;
  logic [23:0]   b_p_r;
  logic [CW-1:0] b_c_r;
  logic [RW-1:0] b_r_r;
  logic          b_cge2_r, b_rone_r, b_rzero_r, b_done;
  logic [23:0]   w0_r, w1_r, w2_r, w3_r, north_prev_r;
  logic [9:0]    colm1, colc, rowm1, rowc;

  always_comb begin
    if (frame_width == 11'd0) begin
      wd_m1 = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      wd_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      wd_m1 = CW'(frame_width - 11'd1);
    end
    if (frame_height == 11'd0) begin
      ht_m1 = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      ht_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      ht_m1 = RW'(frame_height - 11'd1);
    end
  end

  assign c = (col_r > wd_m1) ? wd_m1 : col_r;
  assign r = (row_r > ht_m1) ? ht_m1 : row_r;
  assign lastc = (c == wd_m1);
  assign lastr = (r == ht_m1);
  assign c_nz = (c != '0);
  assign r_nz = (r != '0);
  assign p = in_ch.pixel_in;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {bank_r, c};
    wr_data = p;
    if (accept) begin
      if (c_nz) begin
        wr_en = 1'b1;
        wr_addr = {bank_r, c - CW'(1)};
        wr_data = last_p_r;
      end else if (lastc) begin
        wr_en = 1'b1;
      end else if (pend_v_r) begin
        wr_en = 1'b1;
        wr_addr = pend_addr_r;
        wr_data = pend_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      mid_q <= mem[{~bank_r, c}];
      north_q <= mem[{bank_r, c}];
    end
  end

  always_comb begin
    pick = 4'b0000;
    priority if (mask_r[0]) begin
      pick = 4'b0001;
    end else if (mask_r[1]) begin
      pick = 4'b0010;
    end else if (mask_r[2]) begin
      pick = 4'b0100;
    end else if (mask_r[3]) begin
      pick = 4'b1000;
    end
  end

  assign mask_after = mask_r & ~pick;
  assign job_push = b_valid_r && (mask_r != 4'b0000) && !job_full;
  assign b_done = b_valid_r && ((mask_r == 4'b0000) || (job_push && mask_after == 4'b0000));
  assign in_ch.ready = !b_valid_r || b_done;

  assign colc = 10'(b_c_r);
  assign colm1 = 10'(b_c_r - CW'(1));
  assign rowc = 10'(b_r_r);
  assign rowm1 = 10'(b_r_r - RW'(1));

  always_comb begin
    job = '0;
    job.run_last = (mask_after == 4'b0000);
    priority if (pick[0]) begin
      job.cen = w2_r;
      job.west = b_cge2_r ? w3_r : w2_r;
      job.east = mid_q;
      job.north = b_rone_r ? w2_r : north_prev_r;
      job.south = w0_r;
      job.col = colm1;
      job.row = rowm1;
    end else if (pick[1]) begin
      job.cen = mid_q;
      job.west = (b_c_r != '0) ? w2_r : mid_q;
      job.east = mid_q;
      job.north = b_rone_r ? mid_q : north_q;
      job.south = b_p_r;
      job.col = colc;
      job.row = rowm1;
    end else if (pick[2]) begin
      job.cen = w0_r;
      job.west = b_cge2_r ? w1_r : w0_r;
      job.east = b_p_r;
      job.north = b_rzero_r ? w0_r : w2_r;
      job.south = w0_r;
      job.col = colm1;
      job.row = rowc;
    end else begin
      job.cen = b_p_r;
      job.west = (b_c_r != '0) ? w0_r : b_p_r;
      job.east = b_p_r;
      job.north = b_rzero_r ? b_p_r : mid_q;
      job.south = b_p_r;
      job.col = colc;
      job.row = rowc;
      job.frame_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      bank_r <= 1'b0;
      pend_v_r <= 1'b0;
      b_valid_r <= 1'b0;
      mask_r <= 4'b0000;
      w0_r <= '0;
      w1_r <= '0;
      w2_r <= '0;
      w3_r <= '0;
    end else begin
      if (b_done) begin
        w3_r <= w2_r;
        w2_r <= mid_q;
        w1_r <= w0_r;
        w0_r <= b_p_r;
      end
      if (accept) begin
        b_valid_r <= 1'b1;
        mask_r <= {lastc && lastr, c_nz && lastr, lastc && r_nz, c_nz && r_nz};
        if (lastc) begin
          col_r <= '0;
          row_r <= lastr ? '0 : r + RW'(1);
          bank_r <= ~bank_r;
        end else begin
          col_r <= c + CW'(1);
        end
        if (lastc && c_nz) begin
          pend_v_r <= 1'b1;
        end else if (!c_nz) begin
          pend_v_r <= 1'b0;
        end
      end else begin
        if (b_done) begin
          b_valid_r <= 1'b0;
        end
        if (job_push) begin
          mask_r <= mask_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      north_prev_r <= north_q;
    end
    if (accept) begin
      last_p_r <= p;
      b_p_r <= p;
      b_c_r <= c;
      b_r_r <= r;
      b_cge2_r <= (c > CW'(1));
      b_rone_r <= (r == RW'(1));
      b_rzero_r <= !r_nz;
      pend_addr_r <= {bank_r, c};
      pend_data_r <= p;
    end
  end

endmodule

// File: hw/rtl/cusu_queue.sv
// Short job queue between the front end and the sharpen back end.
module cusu_queue import cusu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_job,
  input  logic push,
  output logic full,
  output job_t head,
  input  logic pop,
  output logic empty
);

  job_t entries [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/cusu_back.sv
// Back end: two-stage sharpen datapath with the result output register.
module cusu_back import cusu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [21:0] sharpen_gain,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  cusu_res_if.source  out_ch
);

  logic s1_valid_r, o_valid_r, out_load, s1_free;
  logic signed [30:0] prod_r [3];
  logic [7:0]  cen_r [3];
  logic [9:0]  s1_col_r, s1_row_r;
  logic        s1_rl_r, s1_fl_r;
  logic [23:0] o_pix_r;
  logic [9:0]  o_col_r, o_row_r;
  logic        o_rl_r, o_fl_r;

  assign out_load = s1_valid_r && (!o_valid_r || out_ch.ready);
  assign s1_free = !s1_valid_r || out_load;
  assign pop = !empty && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= pop;
      end
      if (out_load) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= chan_prod(head.cen[8*k +: 8], head.north[8*k +: 8],
                               head.south[8*k +: 8], head.east[8*k +: 8],
                               head.west[8*k +: 8], $signed(sharpen_gain));
        cen_r[k] <= head.cen[8*k +: 8];
      end
      s1_col_r <= head.col;
      s1_row_r <= head.row;
      s1_rl_r <= head.run_last;
      s1_fl_r <= head.frame_last;
    end
    if (out_load) begin
      for (int k = 0; k < 3; k++) begin
        o_pix_r[8*k +: 8] <= chan_sat(cen_r[k], prod_r[k]);
      end
      o_col_r <= s1_col_r;
      o_row_r <= s1_row_r;
      o_rl_r <= s1_rl_r;
      o_fl_r <= s1_fl_r;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.pixel_out = o_pix_r;
  assign out_ch.out_column = o_col_r;
  assign out_ch.out_row = o_row_r;
  assign out_ch.run_last = o_rl_r;
  assign out_ch.frame_last = o_fl_r;

endmodule

// File: hw/rtl/cusu_checker.sv
// Port-level checker for the sharpen unit and its bind to the top level.
`include "cross_unsharp_sharpen_unit_assert.svh"
module cusu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_out,
  input logic        run_last,
  input logic        frame_last
);

  `CUSU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out))
  `CUSU_ASSERT_IMP(a_frame_last_ends_run, out_valid && frame_last, run_last)
  `CUSU_ASSERT_ALWAYS_NXT(a_reset_clears_out, !rst_n, !out_valid)

endmodule

bind cross_unsharp_sharpen_unit cusu_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pixel_out(out_ch.pixel_out), .run_last(out_ch.run_last), .frame_last(out_ch.frame_last)
);

// File: test/testbench.sv
// Self-checking testbench for the cross unsharp sharpen unit: directed table, random frames.
module testbench;
  import cusu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] pix;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        run_last;
    logic        frame_last;
  } sharp_word_t;

  typedef struct packed {
    logic             setup;
    logic [10:0]      width;
    logic [10:0]      height;
    logic [21:0]      gain;
    logic [23:0]      pix;
    logic [2:0]       n_typed;
    logic [3:0][23:0] typed;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [21:0] cfg_data;

  cusu_pix_if pix_ch();
  cusu_res_if res_ch();

  cross_unsharp_sharpen_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pix_ch), .out_ch(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sharp_word_t pending_q[$];
  int fail_count;
  int burst_left;
  bit steady;

  logic [23:0] row_mem[2][1024];
  logic [23:0] win[4];
  int col_pos;
  int row_pos;
  bit bank;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic signed [21:0] gain_reg;

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(input string what);
    $display("Mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int eff_size(input logic [10:0] v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : int'(v);
  endfunction

  function automatic logic [7:0] sharpen_chan(input int cen, input int n, input int s,
                                              input int e, input int w);
    longint prod;
    longint v;
    prod = longint'(gain_reg) * longint'(cen - ((n + s + e + w) >> 2));
    v = cen + (prod >>> 16);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [23:0] sharpen_pix(input logic [23:0] cen, input logic [23:0] n,
                                              input logic [23:0] s, input logic [23:0] e,
                                              input logic [23:0] w);
    logic [23:0] res;
    for (int sh = 0; sh <= 16; sh += 8) begin
      res[sh +: 8] = sharpen_chan(cen[sh +: 8], n[sh +: 8], s[sh +: 8], e[sh +: 8],
                                  w[sh +: 8]);
    end
    return res;
  endfunction

  function automatic logic [23:0] cur_at(input int x, input int c, input logic [23:0] p);
    if (x == c) return p;
    return (x + 1 == c) ? win[0] : win[1];
  endfunction

  function automatic logic [23:0] mid_at(input int x, input int c);
    if (x == c) return row_mem[!bank][c];
    return (x + 1 == c) ? win[2] : win[3];
  endfunction

  // Applies one accepted word to the shadow state and queues the pixels it releases.
  function automatic int sharpen_step(input logic [23:0] p);
    int wd;
    int ht;
    int c;
    int r;
    int lo;
    int k;
    bit lastc;
    bit lastr;
    logic [23:0] cen;
    logic [23:0] n;
    sharp_word_t w;
    wd = eff_size(width_reg);
    ht = eff_size(height_reg);
    k = 0;
    if (col_pos > wd - 1) col_pos = wd - 1;
    if (row_pos > ht - 1) row_pos = ht - 1;
    c = col_pos;
    r = row_pos;
    lastc = (c == wd - 1);
    lastr = (r == ht - 1);
    lo = (c >= 1) ? c - 1 : c;
    if (r >= 1) begin
      for (int x = lo; x <= c; x++) begin
        if (x == c - 1 || (x == c && lastc)) begin
          cen = mid_at(x, c);
          n = (r == 1) ? cen : row_mem[bank][x];
          w.pix = sharpen_pix(cen, n, cur_at(x, c, p), mid_at(x < c ? x + 1 : x, c),
                              mid_at(x >= 1 ? x - 1 : x, c));
          w.col = x[9:0];
          w.row = 10'(r - 1);
          w.run_last = 1'b0;
          w.frame_last = 1'b0;
          pending_q.push_back(w);
          k++;
        end
      end
    end
    if (lastr) begin
      for (int x = lo; x <= c; x++) begin
        if (x == c - 1 || (x == c && lastc)) begin
          cen = cur_at(x, c, p);
          n = (r == 0) ? cen : mid_at(x, c);
          w.pix = sharpen_pix(cen, n, cen, cur_at(x < c ? x + 1 : x, c, p),
                              cur_at(x >= 1 ? x - 1 : x, c, p));
          w.col = x[9:0];
          w.row = r[9:0];
          w.run_last = 1'b0;
          w.frame_last = (x == c) && lastc;
          pending_q.push_back(w);
          k++;
        end
      end
    end
    if (k > 0) pending_q[pending_q.size() - 1].run_last = 1'b1;
    if (c >= 1) row_mem[bank][c - 1] = win[0];
    if (lastc) row_mem[bank][c] = p;
    win[3] = win[2];
    win[2] = row_mem[!bank][c];
    win[1] = win[0];
    win[0] = p;
    if (lastc) begin
      col_pos = 0;
      row_pos = lastr ? 0 : r + 1;
      bank = !bank;
    end else begin
      col_pos = c + 1;
    end
    return k;
  endfunction

  // Writes all three registers on consecutive edges; the block must be idle.
  task automatic write_regs(input logic [10:0] w, input logic [10:0] h,
                            input logic [21:0] g);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= {11'd0, w};
    @(posedge clk);
    width_reg = w;
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= {11'd0, h};
    @(posedge clk);
    height_reg = h;
    cfg_index <= CFG_SHARPEN_GAIN;
    cfg_data <= g;
    @(posedge clk);
    gain_reg = g;
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_word(input logic [23:0] p, output int k);
    if (burst_left == 0) begin
      if (!steady) begin
        pix_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_in <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    k = sharpen_step(p);
    burst_left--;
  endtask

  task automatic send_frame_rest();
    int k;
    do begin
      send_word(24'($urandom), k);
    end while (col_pos != 0 || row_pos != 0);
  endtask

  stim_row_t stim_table[$];

  function automatic stim_row_t mk(input logic setup, input logic [10:0] w,
                                   input logic [10:0] h, input logic [21:0] g,
                                   input logic [23:0] p, input logic [2:0] n,
                                   input logic [3:0][23:0] t);
    stim_row_t s;
    s = '{setup, w, h, g, p, n, t};
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      case ((int'($time) / 1600) % 4)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 9) < 7);
        2: res_ch.ready <= ($urandom_range(0, 15) == 0);
        default: res_ch.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    sharp_word_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = pending_q.pop_front();
        if (res_ch.pixel_out !== e.pix)
          report($sformatf("pixel_out %h, expected %h", res_ch.pixel_out, e.pix));
        if (res_ch.out_column !== e.col)
          report($sformatf("out_column %0d, expected %0d", res_ch.out_column, e.col));
        if (res_ch.out_row !== e.row)
          report($sformatf("out_row %0d, expected %0d", res_ch.out_row, e.row));
        if (res_ch.run_last !== e.run_last)
          report($sformatf("run_last %b, expected %b", res_ch.run_last, e.run_last));
        if (res_ch.frame_last !== e.frame_last)
          report($sformatf("frame_last %b, expected %b", res_ch.frame_last, e.frame_last));
      end
    end
  end

  initial begin
    int k;
    int rand_items;
    int wd;
    int ht;
    logic [21:0] g;
    fail_count = 0;
    burst_left = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_in = '0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    gain_reg = 22'sd65536;
    col_pos = 0;
    row_pos = 0;
    bank = 1'b0;
    for (int i = 0; i < 4; i++) win[i] = '0;
    for (int i = 0; i < 1024; i++) begin
      row_mem[0][i] = '0;
      row_mem[1][i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gain zero returns the center unchanged, so the 2x2 frame comes back as sent.
    stim_table.push_back(mk(1, 2, 2, 0, 24'hFFFFFF, 0, '0));
    stim_table.push_back(mk(0, 0, 0, 0, 24'h000000, 0, '0));
    stim_table.push_back(mk(0, 0, 0, 0, 24'h123456, 0, '0));
    stim_table.push_back(mk(0, 0, 0, 0, 24'hABCDEF, 4,
                            {24'hABCDEF, 24'h123456, 24'h000000, 24'hFFFFFF}));
    // A single pixel frame has all neighbors equal to the center.
    stim_table.push_back(mk(1, 1, 1, 22'd65536, 24'h5A5A5A, 1, {72'd0, 24'h5A5A5A}));
    stim_table.push_back(mk(1, 0, 0, 22'h1FFFFF, 24'h00FF00, 1, {72'd0, 24'h00FF00}));
    for (int i = 0; i < 9; i++)
      stim_table.push_back(mk(i == 0, 3, 3, 22'h1FFFFF, (i % 2) ? 24'h000000 : 24'hFFFFFF,
                              0, '0));
    for (int i = 0; i < 9; i++)
      stim_table.push_back(mk(i == 0, 3, 3, 22'h200000, (i % 2) ? 24'hFF00FF : 24'h00FF00,
                              0, '0));

    foreach (stim_table[i]) begin
      if (stim_table[i].setup) begin
        drain();
        write_regs(stim_table[i].width, stim_table[i].height, stim_table[i].gain);
      end
      send_word(stim_table[i].pix, k);
      if (k != stim_table[i].n_typed && stim_table[i].n_typed != 0)
        report($sformatf("table row %0d released %0d words", i, k));
      for (int j = 0; j < stim_table[i].n_typed && j < k; j++) begin
        if (pending_q[pending_q.size() - k + j].pix !== stim_table[i].typed[j])
          report($sformatf("table row %0d word %0d differs from typed value", i, j));
      end
    end

    // The frame shrinks under the counters while the block is idle.
    drain();
    write_regs(6, 5, 22'd98304);
    repeat (16) send_word(24'($urandom), k);
    drain();
    write_regs(3, 2, 22'd98304);
    send_frame_rest();

    // Oversized settings act as the maximum; the frame is then cut short.
    drain();
    write_regs(11'd2047, 1, 22'h3FFFFF);
    repeat (20) send_word(24'($urandom), k);
    drain();
    write_regs(3, 1, 22'h3FFFFF);
    send_frame_rest();
    drain();
    write_regs(1, 11'd1500, 22'd131072);
    repeat (20) send_word(24'($urandom), k);
    drain();
    write_regs(1, 2, 22'd131072);
    send_frame_rest();

    rand_items = 0;
    while (rand_items < 280) begin
      drain();
      wd = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32) : $urandom_range(0, 12);
      ht = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0: g = 22'($urandom);
        1: g = 22'($urandom_range(0, 196608));
        2: g = -22'($urandom_range(0, 131072));
        default: g = 22'd65536;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      write_regs(wd[10:0], ht[10:0], g);
      send_frame_rest();
      rand_items += eff_size(wd[10:0]) * eff_size(ht[10:0]);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
